>>> design/csseq_pkg.sv
// Package for the cell scan sequencer: grid limits, derived widths,
// operation, scan mode and register index codes. No dependencies.
package csseq_pkg;

  // Largest grid supported by the changed-mask storage.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  // Coordinate widths inside the core and effective grid size widths.
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HH = $clog2(MAX_HEIGHT + 1);

  // Fixed port widths.
  localparam int COORD_W   = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  // Operation codes of one command beat.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_NEXT  = 2'd1,
    OP_MARK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Scan mode codes.
  localparam logic [1:0] MODE_RASTER   = 2'd0;
  localparam logic [1:0] MODE_CHANGED  = 2'd1;
  localparam logic [1:0] MODE_MARGOLUS = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

endpackage

>>> design/cell_scan_sequencer_core.sv
// Cell scan sequencer top level: command decode, scan sequencer with a
// shared subtract/compare unit, and the changed-mask memory.
// Depends on csseq_pkg.
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  ---------------------------------------
//  command   start, busy (accept: !busy)  op, scan_mode, block_offset, mark_x/y,
//                                         mark_changed
//  config    cfg_valid, cfg_ready         cfg_index, cfg_data
//  result    result_valid (strobe)        cell_x, cell_y, block_pos, scan_done
//
// Start (raster or Margolus), raster next, mark, next after done and the Margolus
// block step answer in the cycle after the command beat. A step inside a Margolus
// block goes through ST_MOD, where the shared subtract unit does one subtraction per
// axis that wraps at the grid edge. A changed-only start or next walks the mask one
// bit per cycle, after a column read in ST_FETCH for each column. A mask clear, and
// the sweep after reset, zero all MAX_WIDTH (256) mask columns with busy high.
// Results are one-cycle strobes; the receiver cannot stall them.
module cell_scan_sequencer_core
  import csseq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Command channel.
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           op,
  input  logic [1:0]           scan_mode,
  input  logic                 block_offset,
  input  logic [COORD_W-1:0]   mark_x,
  input  logic [COORD_W-1:0]   mark_y,
  input  logic                 mark_changed,
  // Configuration channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // Result channel.
  output logic                 result_valid,
  output logic [COORD_W-1:0]   cell_x,
  output logic [COORD_W-1:0]   cell_y,
  output logic [1:0]           block_pos,
  output logic                 scan_done
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_TEST,
    ST_MOD
  } state_t;

  state_t state;

  // Configuration registers.
  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;

  // Scan state.
  logic [XW-1:0] current_x;
  logic [YW-1:0] current_y;
  logic [WW-1:0] block_x;
  logic [HH-1:0] block_y;
  logic          row_origin;
  logic [1:0]    block_position;
  logic [1:0]    active_mode;
  logic          finished;
  logic [WW-1:0] scan_x;
  logic [HH-1:0] scan_y;

  // Operands of the shared wrap unit.
  logic [WW-1:0] rx;
  logic [HH-1:0] ry;
  logic          mod_x;
  logic          mod_y;

  // Clearing sweep.
  logic [XW-1:0] clr_idx;
  logic          clr_reply;

  // Changed mask: one word per column x, one bit per row y.
  logic [MAX_HEIGHT-1:0] mask_mem [MAX_WIDTH];
  logic [MAX_HEIGHT-1:0] row_q;
  logic                  mask_we;
  logic [XW-1:0]         mask_wr_row;
  logic [MAX_HEIGHT-1:0] mask_wr_en;
  logic [MAX_HEIGHT-1:0] mask_wr_bits;

  logic [WW-1:0] w_eff;
  logic [HH-1:0] h_eff;
  logic          accept;
  logic          mark_in_grid;
  logic [1:0]    start_mode;
  logic          off_x;
  logic          off_y;

  // Effective grid sizes: zero acts as one, oversize clamps to the maximum.
  always_comb begin
    if (grid_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(grid_width);
    end
    if (grid_height == '0) begin
      h_eff = HH'(1);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      h_eff = HH'(MAX_HEIGHT);
    end else begin
      h_eff = HH'(grid_height);
    end
  end

  // Command decode helpers.
  assign accept       = start && (state == ST_IDLE);
  assign mark_in_grid = (WW'(mark_x) < w_eff) && (HH'(mark_y) < h_eff);
  assign start_mode   = (scan_mode == MODE_UNUSED) ? MODE_RASTER : scan_mode;
  assign off_x        = block_offset && (w_eff != WW'(1));
  assign off_y        = block_offset && (h_eff != HH'(1));

  // Mask write port: whole column cleared in the sweep, single bit on a mark.
  always_comb begin
    mask_we      = 1'b0;
    mask_wr_row  = XW'(mark_x);
    mask_wr_en   = '0;
    mask_wr_bits = {MAX_HEIGHT{mark_changed}};
    if (state == ST_CLEAR) begin
      mask_we      = 1'b1;
      mask_wr_row  = clr_idx;
      mask_wr_en   = '1;
      mask_wr_bits = '0;
    end else if (accept && (op_t'(op) == OP_MARK) && mark_in_grid) begin
      mask_we                  = 1'b1;
      mask_wr_en[YW'(mark_y)]  = 1'b1;
    end
  end

  // Mask memory with bit-enable writes and a registered column read.
  always_ff @(posedge clk) begin
    if (mask_we) begin
      for (int b = 0; b < MAX_HEIGHT; b++) begin
        if (mask_wr_en[b]) begin
          mask_mem[mask_wr_row][b] <= mask_wr_bits[b];
        end
      end
    end
    row_q <= mask_mem[scan_x[XW-1:0]];
  end

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  // Sequencer: state, scan registers and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_idx        <= '0;
      clr_reply      <= 1'b0;
      grid_width     <= CFG_W'(MAX_WIDTH);
      grid_height    <= CFG_W'(MAX_HEIGHT);
      current_x      <= '0;
      current_y      <= '0;
      block_x        <= '0;
      block_y        <= '0;
      row_origin     <= 1'b0;
      block_position <= '0;
      active_mode    <= MODE_RASTER;
      finished       <= 1'b0;
      scan_x         <= '0;
      scan_y         <= '0;
      mod_x          <= 1'b0;
      mod_y          <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      result_valid <= 1'b0;

      if (cfg_valid) begin
        if (cfg_index == REG_GRID_WIDTH) begin
          grid_width <= cfg_data;
        end else if (cfg_index == REG_GRID_HEIGHT) begin
          grid_height <= cfg_data;
        end
      end

      unique case (state)
        // One mask column per cycle.
        ST_CLEAR: begin
          if (clr_idx == XW'(MAX_WIDTH - 1)) begin
            state        <= ST_IDLE;
            result_valid <= clr_reply;
          end else begin
            clr_idx <= clr_idx + XW'(1);
          end
        end

        ST_IDLE: begin
          if (start) begin
            unique case (op_t'(op))
              OP_START: begin
                finished       <= 1'b0;
                current_x      <= '0;
                current_y      <= '0;
                scan_x         <= '0;
                scan_y         <= '0;
                block_position <= '0;
                active_mode    <= start_mode;
                if (start_mode == MODE_CHANGED) begin
                  state <= ST_FETCH;
                end else begin
                  if (start_mode == MODE_MARGOLUS) begin
                    block_x    <= WW'(off_x);
                    block_y    <= HH'(off_y);
                    row_origin <= off_x;
                    current_x  <= XW'(off_x);
                    current_y  <= YW'(off_y);
                  end
                  result_valid <= 1'b1;
                end
              end

              OP_NEXT: begin
                if (finished) begin
                  result_valid <= 1'b1;
                end else if (active_mode == MODE_CHANGED) begin
                  scan_y <= scan_y + HH'(1);
                  state  <= ST_FETCH;
                end else if (active_mode == MODE_MARGOLUS) begin
                  if (block_position == 2'd3) begin
                    // Step to the next block, or finish after the last one.
                    block_position <= '0;
                    result_valid   <= 1'b1;
                    if (({1'b0, block_x} + (WW+1)'(2)) < {1'b0, w_eff}) begin
                      block_x   <= block_x + WW'(2);
                      current_x <= XW'(block_x + WW'(2));
                      current_y <= YW'(block_y);
                    end else if (({1'b0, block_y} + (HH+1)'(2)) < {1'b0, h_eff}) begin
                      block_x   <= WW'(row_origin);
                      block_y   <= block_y + HH'(2);
                      current_x <= XW'(row_origin);
                      current_y <= YW'(block_y + HH'(2));
                    end else begin
                      finished  <= 1'b1;
                      current_x <= XW'(block_x);
                      current_y <= YW'(block_y);
                    end
                  end else begin
                    // Next cell inside the block; wrap in the shared unit.
                    block_position <= block_position + 2'd1;
                    rx    <= block_x + WW'(1);
                    ry    <= block_y + HH'(1);
                    mod_x <= (block_position != 2'd2);
                    mod_y <= (block_position != 2'd0);
                    if (block_position == 2'd2) begin
                      current_x <= XW'(block_x);
                    end
                    state <= ST_MOD;
                  end
                end else begin
                  // Raster: x first, then y.
                  result_valid <= 1'b1;
                  if ((WW'(current_x) + WW'(1)) < w_eff) begin
                    current_x <= current_x + XW'(1);
                  end else if ((HH'(current_y) + HH'(1)) < h_eff) begin
                    current_x <= '0;
                    current_y <= current_y + YW'(1);
                  end else begin
                    finished <= 1'b1;
                  end
                end
              end

              OP_MARK: begin
                result_valid <= 1'b1;
              end

              OP_CLEAR: begin
                clr_idx   <= '0;
                clr_reply <= 1'b1;
                state     <= ST_CLEAR;
              end
            endcase
          end
        end

        // Column read issued here; data is in row_q next cycle.
        ST_FETCH: begin
          if (scan_x >= w_eff) begin
            finished     <= 1'b1;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            state <= ST_TEST;
          end
        end

        // Test one mask bit per cycle, column-major.
        ST_TEST: begin
          if (scan_y >= h_eff) begin
            scan_y <= '0;
            scan_x <= scan_x + WW'(1);
            state  <= ST_FETCH;
          end else if (row_q[scan_y[YW-1:0]]) begin
            current_x    <= XW'(scan_x);
            current_y    <= YW'(scan_y);
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            scan_y <= scan_y + HH'(1);
          end
        end

        // Shared subtract unit: reduce x, then y, below the grid size.
        ST_MOD: begin
          if (mod_x && (rx >= w_eff)) begin
            rx <= rx - w_eff;
          end else if (mod_y && (ry >= h_eff)) begin
            ry <= ry - h_eff;
          end else begin
            if (mod_x) begin
              current_x <= XW'(rx);
            end
            if (mod_y) begin
              current_y <= YW'(ry);
            end
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result fields come straight from the scan registers.
  assign busy      = (state != ST_IDLE);
  assign cell_x    = COORD_W'(current_x);
  assign cell_y    = COORD_W'(current_y);
  assign block_pos = (active_mode == MODE_MARGOLUS) ? block_position : 2'd0;
  assign scan_done = finished;

endmodule

>>> design/csseq_checker.sv
// Port-level checker for the cell scan sequencer and its bind to the top level.
// Depends on csseq_pkg and cell_scan_sequencer_core.
module csseq_checker
  import csseq_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic [1:0]           op,
  input logic [1:0]           scan_mode,
  input logic                 result_valid,
  input logic [COORD_W-1:0]   cell_x,
  input logic [COORD_W-1:0]   cell_y,
  input logic [1:0]           block_pos,
  input logic                 scan_done
);

  logic cmd_beat;
  assign cmd_beat = start && !busy;

  // Reset starts the mask sweep, so no result follows it.
  a_no_result_after_reset: assert property (
    @(posedge clk) rst |=> !result_valid
  ) else $error("result strobe right after reset");

  // A result is only shown once the sequencer has returned to idle.
  a_idle_on_result: assert property (
    @(posedge clk) disable iff (rst) result_valid |-> !busy
  ) else $error("result strobe while busy");

  // A mark beat answers at once and leaves the current cell alone.
  a_mark_keeps_cell: assert property (
    @(posedge clk) disable iff (rst)
      (cmd_beat && op == OP_MARK) |=>
        (result_valid && $stable(cell_x) && $stable(cell_y) && $stable(scan_done))
  ) else $error("mark beat disturbed the current cell");

  // A raster start answers at once at the origin.
  a_raster_start: assert property (
    @(posedge clk) disable iff (rst)
      (cmd_beat && op == OP_START && scan_mode == MODE_RASTER) |=>
        (result_valid && cell_x == '0 && cell_y == '0 && block_pos == 2'd0 && !scan_done)
  ) else $error("raster start did not return the origin");

  // Next after the scan has finished repeats the last result.
  a_done_holds: assert property (
    @(posedge clk) disable iff (rst)
      (cmd_beat && op == OP_NEXT && scan_done) |=>
        (result_valid && scan_done && $stable(cell_x) && $stable(cell_y))
  ) else $error("next after done changed the result");

endmodule

bind cell_scan_sequencer_core csseq_checker u_csseq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .op           (op),
  .scan_mode    (scan_mode),
  .result_valid (result_valid),
  .cell_x       (cell_x),
  .cell_y       (cell_y),
  .block_pos    (block_pos),
  .scan_done    (scan_done)
);
